@@ rtl/core/sq4_uniform_vector_encoder_macros.svh @@
// Assertion helpers used by the encoder checker
`ifndef SQ4_UNIFORM_VECTOR_ENCODER_MACROS_SVH
`define SQ4_UNIFORM_VECTOR_ENCODER_MACROS_SVH

// same-cycle implication, masked while reset is held
`define SQ4_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sq4 check failed");

// next-cycle implication, masked while reset is held
`define SQ4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sq4 check failed");

// next-cycle implication that also runs across reset
`define SQ4_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sq4 check failed");

`endif

@@ rtl/core/sq4_pkg.sv @@
package sq4_pkg;

    localparam int unsigned MAX_DIM_DEF = 4096;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 11;
    localparam int unsigned NORM_W  = 20;
    localparam int unsigned VSUM_W  = 45;
    localparam int unsigned CSUM_W  = 16;

    localparam logic [CODE_W-1:0] CODE_MAX = 4'hF;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOWER_BOUND = 1'b0;
    localparam t_cfg_idx CFG_INV_RANGE   = 1'b1;

    // product stage result handed to the packer
    typedef struct packed {
        logic                       zero;   // diff <= 0 or inverse range is zero
        logic                       sat;    // delta reached 1.0
        logic [VALUE_W-1:0]         frac;   // fractional part of delta, Q0.32
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } t_prod;

endpackage

@@ rtl/core/sq4_mult.sv @@
module sq4_mult (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [sq4_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    input  logic signed [sq4_pkg::VALUE_W-1:0] i_lower,
    input  logic [sq4_pkg::VALUE_W-1:0]        i_inv,
    output sq4_pkg::t_prod                     o_prod
);

    logic signed [sq4_pkg::VALUE_W:0]     diff;
    logic [2*sq4_pkg::VALUE_W-1:0]        product;
    sq4_pkg::t_prod                       n_prod;
    sq4_pkg::t_prod                       r_prod;

    always_comb begin
        diff    = {i_value[sq4_pkg::VALUE_W-1], i_value}
                - {i_lower[sq4_pkg::VALUE_W-1], i_lower};
        // a positive diff fits in 32 unsigned bits
        product = (2*sq4_pkg::VALUE_W)'(diff[sq4_pkg::VALUE_W-1:0])
                * (2*sq4_pkg::VALUE_W)'(i_inv);
        n_prod.zero  = diff[sq4_pkg::VALUE_W] || (diff == '0) || (i_inv == '0);
        n_prod.sat   = (product[2*sq4_pkg::VALUE_W-1:sq4_pkg::VALUE_W] != '0);
        n_prod.frac  = product[sq4_pkg::VALUE_W-1:0];
        n_prod.value = i_value;
        n_prod.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/sq4_pack.sv @@
module sq4_pack #(
    parameter int unsigned MAX_DIM = sq4_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  sq4_pkg::t_prod                     i_prod,
    input  logic                               i_out_ready,
    output logic                               o_go,
    output logic                               o_out_valid,
    output logic [sq4_pkg::BYTE_W-1:0]         o_code_byte,
    output logic [sq4_pkg::IDX_W-1:0]          o_byte_index,
    output logic [sq4_pkg::NORM_W-1:0]         o_norm,
    output logic signed [sq4_pkg::VSUM_W-1:0]  o_value_sum,
    output logic [sq4_pkg::CSUM_W-1:0]         o_code_sum,
    output logic                               o_last_res
);

    localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);

    logic [CNT_W-1:0]                   r_count;
    logic [sq4_pkg::CODE_W-1:0]         r_pending;
    logic [sq4_pkg::NORM_W-1:0]         r_norm_acc;
    logic signed [sq4_pkg::VSUM_W-1:0]  r_vsum_acc;
    logic [sq4_pkg::CSUM_W-1:0]         r_csum_acc;

    logic                               r_out_valid;
    logic [sq4_pkg::BYTE_W-1:0]         r_code_byte;
    logic [sq4_pkg::IDX_W-1:0]          r_byte_index;
    logic [sq4_pkg::NORM_W-1:0]         r_norm;
    logic signed [sq4_pkg::VSUM_W-1:0]  r_value_sum;
    logic [sq4_pkg::CSUM_W-1:0]         r_code_sum;
    logic                               r_last_res;

    logic [sq4_pkg::VALUE_W+3:0]        scaled;
    logic [sq4_pkg::CODE_W-1:0]         code;
    logic [2*sq4_pkg::CODE_W-1:0]       code_sq;
    logic                               odd;
    logic                               emit;
    logic                               take;
    logic [CNT_W+11:0]                  pos_wide;
    logic [sq4_pkg::NORM_W-1:0]         n_norm_acc;
    logic signed [sq4_pkg::VSUM_W-1:0]  n_vsum_acc;
    logic [sq4_pkg::CSUM_W-1:0]         n_csum_acc;
    logic [sq4_pkg::BYTE_W-1:0]         n_code_byte;

    always_comb begin
        // 15 * frac as (frac << 4) - frac; the code is the integer part
        scaled = {i_prod.frac, 4'b0000} - {4'b0000, i_prod.frac};
        if (i_prod.zero) begin
            code = '0;
        end else if (i_prod.sat) begin
            code = sq4_pkg::CODE_MAX;
        end else begin
            code = scaled[sq4_pkg::VALUE_W+3:sq4_pkg::VALUE_W];
        end
        code_sq = {4'b0000, code} * {4'b0000, code};

        odd  = r_count[0];
        emit = odd || i_prod.last;
        o_go = !i_valid || !emit || !r_out_valid || i_out_ready;
        take = i_valid && o_go;

        pos_wide   = (CNT_W + 12)'(r_count);
        n_norm_acc = r_norm_acc + sq4_pkg::NORM_W'(code_sq);
        n_vsum_acc = r_vsum_acc + sq4_pkg::VSUM_W'(i_prod.value);
        n_csum_acc = r_csum_acc + sq4_pkg::CSUM_W'(code);
        n_code_byte = odd ? {code, r_pending} : {4'b0000, code};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pending   <= '0;
            r_norm_acc  <= '0;
            r_vsum_acc  <= '0;
            r_csum_acc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_prod.last) begin
                    r_count    <= '0;
                    r_pending  <= '0;
                    r_norm_acc <= '0;
                    r_vsum_acc <= '0;
                    r_csum_acc <= '0;
                end else begin
                    r_norm_acc <= n_norm_acc;
                    r_vsum_acc <= n_vsum_acc;
                    r_csum_acc <= n_csum_acc;
                    if (!odd) begin
                        r_pending <= code;
                    end
                    // hold the position once the counter saturates
                    if (r_count < CNT_W'(MAX_DIM)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
            end
            if (take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_code_byte  <= n_code_byte;
            r_byte_index <= pos_wide[11:1];
            r_norm       <= i_prod.last ? n_norm_acc : '0;
            r_value_sum  <= i_prod.last ? n_vsum_acc : '0;
            r_code_sum   <= i_prod.last ? n_csum_acc : '0;
            r_last_res   <= i_prod.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_byte  = r_code_byte;
    assign o_byte_index = r_byte_index;
    assign o_norm       = r_norm;
    assign o_value_sum  = r_value_sum;
    assign o_code_sum   = r_code_sum;
    assign o_last_res   = r_last_res;

endmodule

@@ rtl/core/sq4_uniform_vector_encoder.sv @@
// 4-bit uniform quantizing encoder, one vector element per request.
// Input channel: i_in_valid / o_in_ready carry i_value (signed Q16.16) and
// i_last, which marks the final element of a vector.
// Output channel: o_out_valid / i_out_ready carry one packed byte. Even
// elements land in the low nibble, odd ones in the high nibble; a byte leaves
// after every odd element and after a final even element. The sums o_norm,
// o_value_sum and o_code_sum are non-zero only on the byte with o_last_res.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 lower bound, 1 inverse range); write only while the block is drained.
// A request passes the input register, the product register and the output
// register in that order. Throughput: one request per cycle unless a stalled
// byte holds the pipe; the 32x32 product register sets the depth, and each
// stage advances whenever it is not held.
// Reset (synchronous, active low) clears the configuration, the element
// counter and the running sums, and empties every stage.
// When the receiver stalls, the waiting byte holds; the two earlier stages
// keep filling; o_in_ready drops once both are full and the later one emits.
module sq4_uniform_vector_encoder #(
    parameter int unsigned MAX_DIM = sq4_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  sq4_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [sq4_pkg::VALUE_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [sq4_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sq4_pkg::BYTE_W-1:0]         o_code_byte,
    output logic [sq4_pkg::IDX_W-1:0]          o_byte_index,
    output logic [sq4_pkg::NORM_W-1:0]         o_norm,
    output logic signed [sq4_pkg::VSUM_W-1:0]  o_value_sum,
    output logic [sq4_pkg::CSUM_W-1:0]         o_code_sum,
    output logic                               o_last_res
);

    logic signed [sq4_pkg::VALUE_W-1:0] r_lower;
    logic [sq4_pkg::VALUE_W-1:0]        r_inv;

    logic                               r_s1_valid;
    logic signed [sq4_pkg::VALUE_W-1:0] r_s1_value;
    logic                               r_s1_last;
    logic                               r_s2_valid;

    logic                               s1_go;
    logic                               s2_go;
    sq4_pkg::t_prod                     prod;

    assign s1_go      = !r_s1_valid || s2_go;
    assign o_in_ready = s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_inv   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sq4_pkg::CFG_LOWER_BOUND: r_lower <= i_cfg_data;
                sq4_pkg::CFG_INV_RANGE:   r_inv   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_go) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && i_in_valid) begin
            r_s1_value <= i_value;
            r_s1_last  <= i_last;
        end
    end

    sq4_mult u_mult (
        .i_clk   (i_clk),
        .i_en    (s2_go && r_s1_valid),
        .i_value (r_s1_value),
        .i_last  (r_s1_last),
        .i_lower (r_lower),
        .i_inv   (r_inv),
        .o_prod  (prod)
    );

    sq4_pack #(
        .MAX_DIM (MAX_DIM)
    ) u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s2_valid),
        .i_prod       (prod),
        .i_out_ready  (i_out_ready),
        .o_go         (s2_go),
        .o_out_valid  (o_out_valid),
        .o_code_byte  (o_code_byte),
        .o_byte_index (o_byte_index),
        .o_norm       (o_norm),
        .o_value_sum  (o_value_sum),
        .o_code_sum   (o_code_sum),
        .o_last_res   (o_last_res)
    );

endmodule

@@ rtl/core/sq4_checker.sv @@
`include "sq4_uniform_vector_encoder_macros.svh"

module sq4_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [sq4_pkg::BYTE_W-1:0]         i_code_byte,
    input logic [sq4_pkg::NORM_W-1:0]         i_norm,
    input logic signed [sq4_pkg::VSUM_W-1:0]  i_value_sum,
    input logic [sq4_pkg::CSUM_W-1:0]         i_code_sum,
    input logic                               i_last_res
);

    logic                                                       stall;
    logic                                                       any_sum;
    logic [sq4_pkg::NORM_W+sq4_pkg::VSUM_W+sq4_pkg::CSUM_W:0]   sum_fields;

    assign stall      = i_out_valid && !i_out_ready;
    assign any_sum    = (i_norm != '0) || (i_value_sum != '0) || (i_code_sum != '0);
    assign sum_fields = {i_norm, i_value_sum, i_code_sum, i_last_res};

    // a stalled byte holds
    `SQ4_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stall, i_out_valid && $stable(i_code_byte))

    // the sums and the final flag hold with it
    `SQ4_ASSERT_NEXT(a_stall_sums_hold, i_clk, i_rst_n, stall, $stable(sum_fields))

    // drop the sums on every byte but the final one
    `SQ4_ASSERT_SAME(a_sums_final_only, i_clk, i_rst_n, i_out_valid && !i_last_res, !any_sum)

    // reset empties the output stage
    `SQ4_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind sq4_uniform_vector_encoder sq4_checker u_sq4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_code_byte (o_code_byte),
    .i_norm      (o_norm),
    .i_value_sum (o_value_sum),
    .i_code_sum  (o_code_sum),
    .i_last_res  (o_last_res)
);

@@ dv/sq4_code_byte_checker.sv @@
module sq4_code_byte_checker #(
    parameter int unsigned MAX_DIM = sq4_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  sq4_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [sq4_pkg::VALUE_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [sq4_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [sq4_pkg::BYTE_W-1:0]         i_code_byte,
    input  logic [sq4_pkg::IDX_W-1:0]          i_byte_index,
    input  logic [sq4_pkg::NORM_W-1:0]         i_norm,
    input  logic signed [sq4_pkg::VSUM_W-1:0]  i_value_sum,
    input  logic [sq4_pkg::CSUM_W-1:0]         i_code_sum,
    input  logic                               i_last_res,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct packed {
        logic [sq4_pkg::BYTE_W-1:0] code_byte;
        logic [sq4_pkg::IDX_W-1:0]  byte_index;
        logic [sq4_pkg::NORM_W-1:0] norm;
        logic [sq4_pkg::VSUM_W-1:0] value_sum;
        logic [sq4_pkg::CSUM_W-1:0] code_sum;
        logic                       last;
    } t_code_byte;

    t_code_byte                          bytes_due[$];
    logic signed [sq4_pkg::VALUE_W-1:0]  lower_bound;
    logic [sq4_pkg::VALUE_W-1:0]         inv_range;
    int unsigned                         elem_pos;
    logic [sq4_pkg::CODE_W-1:0]          low_nibble;
    logic [sq4_pkg::NORM_W-1:0]          norm_acc;
    logic [sq4_pkg::VSUM_W-1:0]          value_sum_acc;
    logic [sq4_pkg::CSUM_W-1:0]          code_sum_acc;

    function automatic logic [sq4_pkg::CODE_W-1:0] code_of_value(
        input logic signed [sq4_pkg::VALUE_W-1:0] v);
        logic signed [sq4_pkg::VALUE_W:0] diff;
        logic [2*sq4_pkg::VALUE_W-1:0]    prod;
        logic [sq4_pkg::VALUE_W+3:0]      scaled;
        diff = {v[sq4_pkg::VALUE_W-1], v}
             - {lower_bound[sq4_pkg::VALUE_W-1], lower_bound};
        if (diff[sq4_pkg::VALUE_W] || diff == '0 || inv_range == '0)
            return '0;
        prod = (2*sq4_pkg::VALUE_W)'(diff[sq4_pkg::VALUE_W-1:0])
             * (2*sq4_pkg::VALUE_W)'(inv_range);
        // delta of one or more saturates the code
        if (prod[2*sq4_pkg::VALUE_W-1:sq4_pkg::VALUE_W] != '0)
            return sq4_pkg::CODE_MAX;
        scaled = {4'b0, prod[sq4_pkg::VALUE_W-1:0]}
               * (sq4_pkg::VALUE_W+4)'(sq4_pkg::CODE_MAX);
        return scaled[sq4_pkg::VALUE_W+3:sq4_pkg::VALUE_W];
    endfunction

    task automatic encode_element(input logic signed [sq4_pkg::VALUE_W-1:0] v,
                                  input logic is_last);
        logic [sq4_pkg::CODE_W-1:0] code;
        logic                       odd;
        t_code_byte                 want;
        code = code_of_value(v);
        odd = elem_pos[0];
        norm_acc = norm_acc + sq4_pkg::NORM_W'(code) * sq4_pkg::NORM_W'(code);
        value_sum_acc = value_sum_acc + sq4_pkg::VSUM_W'(v);
        code_sum_acc = code_sum_acc + sq4_pkg::CSUM_W'(code);
        if (odd || is_last) begin
            want.code_byte = odd ? {code, low_nibble} : {4'b0, code};
            want.byte_index = sq4_pkg::IDX_W'(elem_pos >> 1);
            want.norm = is_last ? norm_acc : '0;
            want.value_sum = is_last ? value_sum_acc : '0;
            want.code_sum = is_last ? code_sum_acc : '0;
            want.last = is_last;
            bytes_due.push_back(want);
        end
        if (!odd)
            low_nibble = code;
        if (is_last) begin
            elem_pos = 0;
            low_nibble = '0;
            norm_acc = '0;
            value_sum_acc = '0;
            code_sum_acc = '0;
        end else if (elem_pos < MAX_DIM) begin
            // the position sticks once the counter saturates
            elem_pos++;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        o_fail_count++;
        $display("%0t: %s got %0h, want %0h", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin : track
        t_code_byte want;
        if (!i_rst_n) begin
            bytes_due.delete();
            lower_bound = '0;
            inv_range = '0;
            elem_pos = 0;
            low_nibble = '0;
            norm_acc = '0;
            value_sum_acc = '0;
            code_sum_acc = '0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sq4_pkg::CFG_LOWER_BOUND: lower_bound = i_cfg_data;
                    sq4_pkg::CFG_INV_RANGE:   inv_range = i_cfg_data;
                    default:                  ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch("byte with nothing due", 64'(i_code_byte), '0);
                end else begin
                    want = bytes_due.pop_front();
                    if (i_code_byte !== want.code_byte)
                        report_mismatch("code_byte", 64'(i_code_byte), 64'(want.code_byte));
                    if (i_byte_index !== want.byte_index)
                        report_mismatch("byte_index", 64'(i_byte_index),
                                        64'(want.byte_index));
                    if (i_norm !== want.norm)
                        report_mismatch("norm", 64'(i_norm), 64'(want.norm));
                    if (i_value_sum !== want.value_sum)
                        report_mismatch("value_sum", 64'(i_value_sum), 64'(want.value_sum));
                    if (i_code_sum !== want.code_sum)
                        report_mismatch("code_sum", 64'(i_code_sum), 64'(want.code_sum));
                    if (i_last_res !== want.last)
                        report_mismatch("last_res", 64'(i_last_res), 64'(want.last));
                end
            end
            if (i_in_valid && i_in_ready)
                encode_element(i_value, i_last);
        end
        o_pending = bytes_due.size();
    end

endmodule

@@ dv/sq4_uniform_vector_encoder_tb.sv @@
module sq4_uniform_vector_encoder_tb;

    localparam int unsigned MAX_DIM = sq4_pkg::MAX_DIM_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 45;
    localparam int EXTREME_LEN = 48;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    sq4_pkg::t_cfg_idx                   i_cfg_idx = sq4_pkg::CFG_LOWER_BOUND;
    logic [sq4_pkg::VALUE_W-1:0]         i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic signed [sq4_pkg::VALUE_W-1:0]  i_value = '0;
    logic                                i_last = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic [sq4_pkg::BYTE_W-1:0]          o_code_byte;
    logic [sq4_pkg::IDX_W-1:0]           o_byte_index;
    logic [sq4_pkg::NORM_W-1:0]          o_norm;
    logic signed [sq4_pkg::VSUM_W-1:0]   o_value_sum;
    logic [sq4_pkg::CSUM_W-1:0]          o_code_sum;
    logic                                o_last_res;

    int                                  mismatches;
    int                                  bytes_due;
    int                                  hold_req = 0;
    int                                  burst_left = 0;
    bit                                  no_gaps = 1'b0;
    int                                  idle_cycles = 0;
    logic signed [sq4_pkg::VALUE_W-1:0]  cur_lower = '0;
    logic [sq4_pkg::VALUE_W-1:0]         cur_inv = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sq4_uniform_vector_encoder #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_code_byte (o_code_byte),
        .o_byte_index(o_byte_index),
        .o_norm      (o_norm),
        .o_value_sum (o_value_sum),
        .o_code_sum  (o_code_sum),
        .o_last_res  (o_last_res)
    );

    sq4_code_byte_checker #(
        .MAX_DIM(MAX_DIM)
    ) u_code_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_code_byte (o_code_byte),
        .i_byte_index(o_byte_index),
        .i_norm      (o_norm),
        .i_value_sum (o_value_sum),
        .i_code_sum  (o_code_sum),
        .i_last_res  (o_last_res),
        .o_fail_count(mismatches),
        .o_pending   (bytes_due)
    );

    // receiver: random stall modes, plus a long hold-off on demand
    initial begin : receiver
        int mode;
        int left;
        int tick;
        int hold_done;
        mode = 0;
        left = 0;
        tick = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_out_ready <= ((tick % 4) != 3);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_element(input logic [sq4_pkg::VALUE_W-1:0] v, input logic lst);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_value <= v;
        i_last <= lst;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop the request line and let every byte and trailing element settle
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (bytes_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input sq4_pkg::t_cfg_idx idx,
                             input logic [sq4_pkg::VALUE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [sq4_pkg::VALUE_W-1:0] lower,
                              input logic [sq4_pkg::VALUE_W-1:0] inv);
        wait_for_drain();
        write_reg(sq4_pkg::CFG_LOWER_BOUND, lower);
        write_reg(sq4_pkg::CFG_INV_RANGE, inv);
        cur_lower = lower;
        cur_inv = inv;
    endtask

    function automatic logic [sq4_pkg::VALUE_W-1:0] pick_value();
        logic [63:0]                 span;
        logic [sq4_pkg::VALUE_W-1:0] off;
        int                          kind;
        kind = $urandom_range(0, 9);
        if (cur_inv == '0 || kind < 2)
            return $urandom;
        span = 64'h1_0000_0000 / cur_inv;
        if (span > 64'h3FFF_FFFF)
            span = 64'h3FFF_FFFF;
        if (kind == 2) begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return cur_lower;
                3:       return cur_lower + span[sq4_pkg::VALUE_W-1:0];
                default: return cur_lower + span[sq4_pkg::VALUE_W-1:0] - 1;
            endcase
        end
        // mostly around the trained range, a little either side
        off = $urandom_range(0, span[sq4_pkg::VALUE_W-1:0] + span[sq4_pkg::VALUE_W-1:0] / 4);
        return cur_lower - span[sq4_pkg::VALUE_W-1:0] / 8 + off;
    endfunction

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_element(pick_value(), i == len - 1);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 12);
        if (r < 19)
            return $urandom_range(13, 64);
        return $urandom_range(65, 200);
    endfunction

    initial begin : stimulus
        int                          n;
        int                          len;
        logic [sq4_pkg::VALUE_W-1:0] lower;
        logic [sq4_pkg::VALUE_W-1:0] range_q;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero range from reset: every code is 0, last on an odd and on an even element
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b1);
        send_element(32'h0005_0000, 1'b1);

        // range -1.0 .. 1.0: below, at and above the bounds
        set_config(32'hFFFF_0000, 32'h0000_8000);
        send_element(32'hFFFF_0000, 1'b0);
        send_element(32'h0001_0000, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'h0000_FFFF, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'hFFFE_FFFF, 1'b0);
        send_element(32'h0000_8000, 1'b1);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b1);

        // extreme registers
        set_config(32'h8000_0000, 32'hFFFF_FFFF);
        send_element(32'h8000_0001, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h0000_0000, 1'b1);
        set_config(32'h7FFF_FFFF, 32'h0001_0000);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 5)
                0: set_config($urandom, $urandom);
                1: set_config($urandom, 32'h0);
                default: begin
                    lower = -$urandom_range(0, 32'h0008_0000);
                    range_q = $urandom_range(32'h0000_1000, 32'h0010_0000);
                    set_config(lower, 32'(33'h1_0000_0000 / range_q));
                end
            endcase
            no_gaps = (phase == 4);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (phase == 3 && n == 0) begin
                    // hold the receiver off while requests keep coming
                    hold_req++;
                    no_gaps = 1'b1;
                    send_vector(40);
                    no_gaps = 1'b0;
                    n += 40;
                end
                if (phase == 7 && n > PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 13)
                    wait_for_drain();
                len = pick_length();
                send_vector(len);
                n += len;
            end
        end

        // a longer vector at the register extremes
        set_config(32'h8000_0000, 32'hFFFF_FFFF);
        send_vector(EXTREME_LEN);

        wait_for_drain();
        if (mismatches == 0 && bytes_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sq4_pkg.sv
rtl/core/sq4_mult.sv
rtl/core/sq4_pack.sv
rtl/core/sq4_uniform_vector_encoder.sv
rtl/core/sq4_checker.sv
dv/sq4_code_byte_checker.sv
dv/sq4_uniform_vector_encoder_tb.sv
